// File: sv/assert_macros.svh
// assertion macros used by the top level rtl file of the vertex transform
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define MVT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MVT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/mvt_pkg.sv
// shared types, widths and register codes for the 4x4 vertex transform
// no dependencies
`default_nettype none

package mvt_pkg;

  localparam int WORD_W    = 32;             // element and vertex component width
  localparam int FRAC_W    = 16;             // fraction bits, Q16.16
  localparam int HALF_W    = 32;             // one half of a config register
  localparam int CFG_W     = 2 * HALF_W;     // config register width
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);
  localparam int DIM       = 4;
  localparam int PROD_W    = 2 * WORD_W;     // exact product
  localparam int PAIR_W    = PROD_W + 1;     // sum of two products
  localparam int SUM_W     = PROD_W + 2;     // sum of four products
  localparam int BUS_W     = DIM * WORD_W;   // stream payload width

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef word_t vec_t   [DIM];
  typedef word_t mat_t   [DIM][DIM];
  typedef prod_t prods_t [DIM][DIM];
  typedef pair_t pairs_t [DIM][2];
  typedef sum_t  sums_t  [DIM];

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS01 = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS23 = CFG_IDX_W'(7);

  // 1.0 in fixed point, placed in the low or high half
  localparam logic [HALF_W-1:0] FX_ONE  = HALF_W'(1) << FRAC_W;
  localparam logic [CFG_W-1:0]  ONE_LO  = {{HALF_W{1'b0}}, FX_ONE};
  localparam logic [CFG_W-1:0]  ONE_HI  = {FX_ONE, {HALF_W{1'b0}}};
  localparam logic [CFG_W-1:0]  ZERO_CF = '0;

  // identity matrix
  localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
    ONE_LO, ZERO_CF, ONE_HI, ZERO_CF, ZERO_CF, ONE_LO, ZERO_CF, ONE_HI
  };

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

endpackage

`default_nettype wire

// File: sv/mat4_vertex_transform.sv
// top level of the 4x4 matrix by homogeneous vertex transform
// depends on mvt_pkg, mvt_mul, mvt_acc, mvt_sat and assert_macros.svh
//
//   channel  dir  handshake              payload
//   in_      in   in_tvalid/in_tready    in_tdata: vertex x, y, z, w
//   out_     out  out_tvalid/out_tready  out_tdata: transformed x, y, z, w
//   cfg_     in   cfg_we                 cfg_index, cfg_data: matrix halves
//
// one vertex per cycle sustained while out_tready is high; each transaction passes
// four register stages (multiply, two adder levels, shift and saturate) on its
// way to the output
// every stage has its own valid bit and loads when it is empty or the stage
// after it takes its word, so a stalled output freezes the full stages only
// reset clears the valid bits and loads the identity matrix
`default_nettype none
`include "assert_macros.svh"

module mat4_vertex_transform (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [mvt_pkg::BUS_W-1:0]             in_tdata,   // vx, vy, vz, vw
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [mvt_pkg::BUS_W-1:0]                  out_tdata,  // tx, ty, tz, tw
  input  wire logic                                  cfg_we,
  input  wire logic [mvt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [mvt_pkg::CFG_W-1:0]             cfg_data
);

  logic [mvt_pkg::CFG_W-1:0] cfg_r [mvt_pkg::NUM_REGS];

  mvt_pkg::vec_t   vec;
  mvt_pkg::mat_t   mat;
  mvt_pkg::prods_t prod;
  mvt_pkg::sums_t  sum;
  mvt_pkg::vec_t   res;

  logic mul_valid;
  logic acc_ready;
  logic acc_valid;
  logic sat_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mvt_pkg::NUM_REGS; i++) begin
        cfg_r[i] <= mvt_pkg::CFG_RESET[i];
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        mvt_pkg::REG_ROW0_COLS01: cfg_r[0] <= cfg_data;
        mvt_pkg::REG_ROW0_COLS23: cfg_r[1] <= cfg_data;
        mvt_pkg::REG_ROW1_COLS01: cfg_r[2] <= cfg_data;
        mvt_pkg::REG_ROW1_COLS23: cfg_r[3] <= cfg_data;
        mvt_pkg::REG_ROW2_COLS01: cfg_r[4] <= cfg_data;
        mvt_pkg::REG_ROW2_COLS23: cfg_r[5] <= cfg_data;
        mvt_pkg::REG_ROW3_COLS01: cfg_r[6] <= cfg_data;
        mvt_pkg::REG_ROW3_COLS23: cfg_r[7] <= cfg_data;
        default: ;
      endcase
    end
  end

  // register 2r holds columns 0 and 1 of row r, register 2r+1 columns 2 and 3
  always_comb begin
    for (int c = 0; c < mvt_pkg::DIM; c++) begin
      vec[c] = in_tdata[c*mvt_pkg::WORD_W +: mvt_pkg::WORD_W];
    end
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      for (int c = 0; c < mvt_pkg::DIM; c++) begin
        mat[r][c] = cfg_r[2*r + c/2][(c%2)*mvt_pkg::HALF_W +: mvt_pkg::WORD_W];
      end
    end
    for (int c = 0; c < mvt_pkg::DIM; c++) begin
      out_tdata[c*mvt_pkg::WORD_W +: mvt_pkg::WORD_W] = res[c];
    end
  end

  mvt_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .vec       (vec),
    .mat       (mat),
    .out_valid (mul_valid),
    .out_ready (acc_ready),
    .prod      (prod)
  );

  mvt_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_valid),
    .in_ready  (acc_ready),
    .prod      (prod),
    .out_valid (acc_valid),
    .out_ready (sat_ready),
    .sum       (sum)
  );

  mvt_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (acc_valid),
    .in_ready  (sat_ready),
    .sum       (sum),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res)
  );

  // the pipeline only pushes back when the output itself is stalled
  `MVT_ASSERT(a_stall_source, clk, rst_n, !in_tready |-> (out_tvalid && !out_tready), "input stalled without output backpressure")

  // a product word waiting on the adder tree is not dropped
  `MVT_ASSERT(a_mul_hold, clk, rst_n, (mul_valid && !acc_ready) |=> mul_valid, "product stage lost a transaction under stall")

  // output ready frees the whole pipeline at once
  `MVT_ASSERT(a_ready_chain, clk, rst_n, out_tready |-> (sat_ready && acc_ready && in_tready), "ready did not reach the input")

  // reset empties the pipeline
  `MVT_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!out_tvalid && !mul_valid && !acc_valid), "pipeline not empty after reset")

endmodule

`default_nettype wire

// File: sv/mvt_mul.sv
// stage 1: sixteen signed element-by-component products, registered
// depends on mvt_pkg
`default_nettype none

module mvt_mul (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire mvt_pkg::vec_t  vec,
  input  wire mvt_pkg::mat_t  mat,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mvt_pkg::prods_t     prod
);

  logic             valid_r;
  mvt_pkg::prods_t  prod_r;
  mvt_pkg::prods_t  prod_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign prod      = prod_r;

  always_comb begin
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      for (int c = 0; c < mvt_pkg::DIM; c++) begin
        prod_nxt[r][c] = mvt_pkg::prod_t'(mat[r][c]) * mvt_pkg::prod_t'(vec[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/mvt_acc.sv
// stages 2 and 3: exact adder tree over the four products of each row
// depends on mvt_pkg
`default_nettype none

module mvt_acc (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mvt_pkg::prods_t  prod,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output mvt_pkg::sums_t        sum
);

  logic             pair_valid_r;
  logic             sum_valid_r;
  logic             pair_ready;
  logic             sum_ready;
  mvt_pkg::pairs_t  pair_r;
  mvt_pkg::pairs_t  pair_nxt;
  mvt_pkg::sums_t   sum_r;
  mvt_pkg::sums_t   sum_nxt;

  assign sum_ready  = !sum_valid_r || out_ready;
  assign pair_ready = !pair_valid_r || sum_ready;
  assign in_ready   = pair_ready;
  assign out_valid  = sum_valid_r;
  assign sum        = sum_r;

  always_comb begin
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      pair_nxt[r][0] = mvt_pkg::pair_t'(prod[r][0]) + mvt_pkg::pair_t'(prod[r][1]);
      pair_nxt[r][1] = mvt_pkg::pair_t'(prod[r][2]) + mvt_pkg::pair_t'(prod[r][3]);
      sum_nxt[r]     = mvt_pkg::sum_t'(pair_r[r][0]) + mvt_pkg::sum_t'(pair_r[r][1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_valid_r <= 1'b0;
      sum_valid_r  <= 1'b0;
    end else begin
      if (pair_ready) begin
        pair_valid_r <= in_valid;
      end
      if (sum_ready) begin
        sum_valid_r <= pair_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pair_ready && in_valid) begin
      pair_r <= pair_nxt;
    end
    if (sum_ready && pair_valid_r) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/mvt_sat.sv
// stage 4: floor shift by the fraction width, saturation, output register
// depends on mvt_pkg
`default_nettype none

module mvt_sat (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire mvt_pkg::sums_t  sum,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output mvt_pkg::vec_t        res
);

  localparam mvt_pkg::sum_t SAT_MAX = mvt_pkg::sum_t'(mvt_pkg::WORD_MAX);
  localparam mvt_pkg::sum_t SAT_MIN = mvt_pkg::sum_t'(mvt_pkg::WORD_MIN);

  logic            valid_r;
  mvt_pkg::vec_t   res_r;
  mvt_pkg::vec_t   res_nxt;
  mvt_pkg::sums_t  shifted;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res       = res_r;

  always_comb begin
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      // arithmetic shift rounds toward minus infinity
      shifted[r] = sum[r] >>> mvt_pkg::FRAC_W;
      if (shifted[r] > SAT_MAX) begin
        res_nxt[r] = mvt_pkg::WORD_MAX;
      end else if (shifted[r] < SAT_MIN) begin
        res_nxt[r] = mvt_pkg::WORD_MIN;
      end else begin
        res_nxt[r] = shifted[r][mvt_pkg::WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire
